/* hdl/slrp_pkg.sv */
// slrp_pkg: shared types and constants of the server list reply parser.
// Used by slrp_parse, slrp_outq and server_list_reply_parser_top.
`timescale 1ns / 1ps

package slrp_pkg;

  localparam int unsigned GroupLen = 6;
  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqPtrW = $clog2(OutqDepth);

  // packet status codes
  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_MORE = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;
  localparam logic [1:0] ST_BAD_HDR = 2'd3;

  // result kinds
  localparam logic KIND_SERVER = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [1:0]  packet_status;
    logic        last_of_run;
  } result_t;

  // results produced by one accepted byte: a server record, then a status
  typedef struct packed {
    logic    rec_valid;
    result_t rec;
    logic    stat_valid;
    result_t stat;
  } push_t;

  // expected reply header FF FF FF FF 66 0A
  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd4:    b = 8'h66;
      3'd5:    b = 8'h0A;
      default: b = 8'hFF;
    endcase
    return b;
  endfunction

endpackage

/* hdl/slrp_parse.sv */
// slrp_parse: per-byte parsing state (header check, record assembly) and the
// results each accepted byte produces. Depends on slrp_pkg.
`timescale 1ns / 1ps

module slrp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             packet_end,
  output slrp_pkg::push_t  push
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_RECORDS = 2'd1,
    PH_ENDED   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  gpos_r, gpos_nxt;
  logic        mismatch_r, mismatch_nxt;
  logic [39:0] rec_r, rec_nxt;

  logic [2:0]  pos;
  logic        group_done;
  logic        have_rec;
  logic [31:0] ip;
  logic [15:0] port;
  logic [1:0]  status;

  always_comb begin
    pos = (gpos_r < 3'(slrp_pkg::GroupLen)) ? gpos_r : 3'd0;
    group_done = (pos == 3'(slrp_pkg::GroupLen - 1));
    phase_nxt = phase_r;
    mismatch_nxt = mismatch_r;
    rec_nxt = rec_r;
    have_rec = 1'b0;
    ip = rec_r[39:8];
    port = {rec_r[7:0], data_byte};
    unique case (phase_r)
      PH_HEADER: begin
        if (data_byte != slrp_pkg::hdr_byte(pos)) mismatch_nxt = 1'b1;
        if (group_done) phase_nxt = PH_RECORDS;
      end
      PH_RECORDS: begin
        if (group_done) begin
          rec_nxt = '0;
          if (ip == 32'd0) phase_nxt = PH_ENDED;
          else if (!mismatch_r) have_rec = 1'b1;
        end else begin
          rec_nxt = {rec_r[31:0], data_byte};
        end
      end
      default: ;  // list ended: bytes only counted
    endcase
    gpos_nxt = group_done ? 3'd0 : pos + 3'd1;

    if (gpos_nxt != 3'd0) status = slrp_pkg::ST_BAD_LEN;
    else if (mismatch_nxt) status = slrp_pkg::ST_BAD_HDR;
    else if (phase_nxt == PH_ENDED) status = slrp_pkg::ST_COMPLETE;
    else status = slrp_pkg::ST_MORE;

    push.rec_valid = accept && have_rec;
    push.rec.result_kind = slrp_pkg::KIND_SERVER;
    push.rec.server_ip = ip;
    push.rec.server_port = port;
    push.rec.packet_status = 2'd0;
    push.rec.last_of_run = !packet_end;
    push.stat_valid = accept && packet_end;
    push.stat.result_kind = slrp_pkg::KIND_STATUS;
    push.stat.server_ip = '0;
    push.stat.server_port = '0;
    push.stat.packet_status = status;
    push.stat.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      gpos_r <= '0;
      mismatch_r <= 1'b0;
      rec_r <= '0;
    end else if (accept) begin
      if (packet_end) begin
        // back to the reset state for the next packet
        phase_r <= PH_HEADER;
        gpos_r <= '0;
        mismatch_r <= 1'b0;
        rec_r <= '0;
      end else begin
        phase_r <= phase_nxt;
        gpos_r <= gpos_nxt;
        mismatch_r <= mismatch_nxt;
        rec_r <= rec_nxt;
      end
    end
  end

endmodule

/* hdl/slrp_outq.sv */
// slrp_outq: small result queue taking up to two results per cycle and
// handing out one per transfer. Depends on slrp_pkg.
`timescale 1ns / 1ps

module slrp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  slrp_pkg::push_t     push,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_ready,
  output slrp_pkg::result_t   out_res
);

  localparam int unsigned PW = slrp_pkg::OutqPtrW;

  slrp_pkg::result_t mem_r [slrp_pkg::OutqDepth];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, wsecond;
  logic [PW:0]   count_r, count_nxt;
  logic [1:0]    push_n;
  logic          pop;

  always_comb begin
    pop = out_valid && out_ready;
    push_n = {1'b0, push.rec_valid} + {1'b0, push.stat_valid};
    wsecond = wptr_r + PW'(push.rec_valid);
    wptr_nxt = wptr_r + PW'(push_n);
    count_nxt = count_r + (PW+1)'(push_n) - (PW+1)'(pop);
  end

  assign out_valid = (count_r != '0);
  assign out_res = mem_r[rptr_r];
  // room for the worst case of one byte: record plus status
  assign room2 = (count_r <= (PW+1)'(slrp_pkg::OutqDepth - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      count_r <= count_nxt;
      if (pop) rptr_r <= rptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.rec_valid) mem_r[wptr_r] <= push.rec;
    if (push.stat_valid) mem_r[wsecond] <= push.stat;
  end

endmodule

/* hdl/server_list_reply_parser_top.sv */
// Server list reply parser, top level. Depends on slrp_pkg, slrp_parse, slrp_outq.
// Throughput: one byte per cycle while in_ready is high; a byte ending a packet on
// a record boundary yields two results, drained one per cycle while out_ready is
// high through a 4-entry result queue, which offers results in arrival order.
// Input ready is low while the queue cannot take two more results.
// Reset (synchronous, active low) clears parse state and empties the queue.
`timescale 1ns / 1ps

module server_list_reply_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [31:0] out_server_ip,
  output logic [15:0] out_server_port,
  output logic [1:0]  out_packet_status,
  output logic        out_last_of_run
);

  slrp_pkg::push_t   push;
  slrp_pkg::result_t res;
  logic              room2;
  logic              accept;

  assign in_ready = room2;
  assign accept = in_valid && in_ready;

  slrp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .packet_end (in_packet_end),
    .push       (push)
  );

  slrp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_result_kind = res.result_kind;
  assign out_server_ip = res.server_ip;
  assign out_server_port = res.server_port;
  assign out_packet_status = res.packet_status;
  assign out_last_of_run = res.last_of_run;

endmodule

/* hdl/slrp_checker.sv */
// slrp_checker: port-level checks of the server list reply parser,
// bound to server_list_reply_parser_top. Depends on slrp_pkg.
`timescale 1ns / 1ps

module slrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [31:0] out_server_ip,
  input logic [15:0] out_server_port,
  input logic [1:0]  out_packet_status,
  input logic        out_last_of_run
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // first cycle out of reset: queue empty, input open
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && in_ready)
    else $error("result offered or input blocked right after reset");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == slrp_pkg::KIND_STATUS |->
      out_last_of_run && out_server_ip == 32'd0 && out_server_port == 16'd0)
    else $error("malformed status result");

  a_record_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == slrp_pkg::KIND_SERVER |->
      out_packet_status == 2'd0 && out_server_ip != 32'd0)
    else $error("malformed server record");

endmodule

bind server_list_reply_parser_top slrp_checker u_slrp_checker (.*);

/* tb/server_list_reply_parser_top_tb.sv */
// Self-checking testbench for server_list_reply_parser_top.
// Depends on slrp_pkg and the parser RTL: a directed table, then random reply
// packets, with every result transfer checked against a built-in parse model.
`timescale 1ns / 1ps

module server_list_reply_parser_top_tb;

  localparam int unsigned NumBytes = 1750;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldStart = 300;
  localparam int unsigned HoldLen = 400;
  localparam logic [47:0] ReplyHdr = 48'hFFFF_FFFF_660A;

  typedef enum logic [1:0] {PH_HDR, PH_LIST, PH_ENDED} phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       pend;
    logic       typed;  // status below is the expected one
    logic [1:0] stat;
  } dir_row_t;

  localparam int unsigned NumDir = 25;
  localparam dir_row_t DirRows [NumDir] = '{
    // one-byte packet
    '{8'h00, 1'b1, 1'b1, slrp_pkg::ST_BAD_LEN},
    // good header, all-ones record on the final byte: record plus status
    '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'h66, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'h0A, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b1, 1'b1, slrp_pkg::ST_MORE},
    // header mismatch on the first byte
    '{8'h00, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'h66, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'h0A, 1'b1, 1'b1, slrp_pkg::ST_BAD_HDR},
    // header only, no terminator
    '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'hFF, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE},
    '{8'h66, 1'b0, 1'b0, slrp_pkg::ST_COMPLETE}, '{8'h0A, 1'b1, 1'b1, slrp_pkg::ST_MORE}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_packet_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [31:0] out_server_ip;
  logic [15:0] out_server_port;
  logic [1:0]  out_packet_status;
  logic        out_last_of_run;

  // parse model state
  phase_t      mdl_phase = PH_HDR;
  logic [2:0]  mdl_pos = '0;
  logic        mdl_hdr_bad = 1'b0;
  logic [39:0] mdl_rec = '0;

  slrp_pkg::result_t pending_results [$];
  int          err_count = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;

  server_list_reply_parser_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_packet_end     (in_packet_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_server_ip     (out_server_ip),
    .out_server_port   (out_server_port),
    .out_packet_status (out_packet_status),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the parse model by one byte; returns record (if any) and status (if any).
  task automatic parse_byte_expect(input logic [7:0] b, input logic e,
                                   output logic rec_vld, output slrp_pkg::result_t rec,
                                   output logic stat_vld, output slrp_pkg::result_t stat);
    logic [2:0]  pos;
    logic        group_done;
    logic [31:0] ip;
    logic [15:0] port;
    pos = (mdl_pos < slrp_pkg::GroupLen) ? mdl_pos : 3'd0;
    group_done = (pos == slrp_pkg::GroupLen - 1);
    rec_vld = 1'b0;
    stat_vld = 1'b0;
    ip = '0;
    port = '0;
    rec = '0;
    stat = '0;
    case (mdl_phase)
      PH_HDR: begin
        if (b != ReplyHdr[47 - 8 * pos -: 8]) mdl_hdr_bad = 1'b1;
        if (group_done) mdl_phase = PH_LIST;
      end
      PH_LIST: begin
        if (group_done) begin
          ip = mdl_rec[39:8];
          port = {mdl_rec[7:0], b};
          mdl_rec = '0;
          if (ip == '0) mdl_phase = PH_ENDED;
          else if (!mdl_hdr_bad) rec_vld = 1'b1;
        end else begin
          mdl_rec = {mdl_rec[31:0], b};
        end
      end
      default: ;  // list ended: bytes only count toward length
    endcase
    mdl_pos = group_done ? 3'd0 : pos + 3'd1;
    if (rec_vld) begin
      rec.result_kind = slrp_pkg::KIND_SERVER;
      rec.server_ip = ip;
      rec.server_port = port;
      rec.last_of_run = !e;
    end
    if (e) begin
      stat_vld = 1'b1;
      stat.result_kind = slrp_pkg::KIND_STATUS;
      stat.last_of_run = 1'b1;
      if (mdl_pos != 0) stat.packet_status = slrp_pkg::ST_BAD_LEN;
      else if (mdl_hdr_bad) stat.packet_status = slrp_pkg::ST_BAD_HDR;
      else if (mdl_phase == PH_ENDED) stat.packet_status = slrp_pkg::ST_COMPLETE;
      else stat.packet_status = slrp_pkg::ST_MORE;
      mdl_phase = PH_HDR;
      mdl_pos = '0;
      mdl_hdr_bad = 1'b0;
      mdl_rec = '0;
    end
  endtask

  // Offer one byte in bursts with random gaps; return after its transfer.
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_packet_end <= e;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
  endtask

  // Send a byte and queue what it should produce; a typed status overrides the model.
  task automatic feed_byte(input logic [7:0] b, input logic e, input logic typed,
                           input logic [1:0] stat_code);
    logic              rec_vld, stat_vld;
    slrp_pkg::result_t rec, stat;
    send_byte(b, e);
    parse_byte_expect(b, e, rec_vld, rec, stat_vld, stat);
    if (typed) begin
      stat = '0;
      stat.result_kind = slrp_pkg::KIND_STATUS;
      stat.packet_status = stat_code;
      stat.last_of_run = 1'b1;
      stat_vld = 1'b1;
    end
    if (rec_vld) pending_results = {pending_results, rec};
    if (stat_vld) pending_results = {pending_results, stat};
  endtask

  // Mostly well-formed replies with random records; some noise packets.
  task automatic send_packet();
    logic [7:0]  pkt [$];
    logic [31:0] ip;
    int          n_rec, term_at, tail, bad_at;
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 14)) pkt = {pkt, 8'($urandom_range(0, 255))};
    end else begin
      bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 6;
      n_rec = $urandom_range(0, 5);
      term_at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n_rec) : -1;
      tail = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
      for (int i = 0; i < 6; i++) begin
        pkt = {pkt, ReplyHdr[47 - 8 * i -: 8] ^
                    ((i == bad_at) ? 8'($urandom_range(1, 255)) : 8'h00)};
      end
      for (int r = 0; r <= n_rec; r++) begin
        if (r == n_rec && term_at != n_rec) break;
        for (int k = 0; k < 4; k++) begin
          ip[31 - 8 * k -: 8] = ($urandom_range(0, 3) == 0) ? 8'h00
                                                            : 8'($urandom_range(0, 255));
        end
        if (r == term_at) ip = '0;
        for (int k = 0; k < 4; k++) pkt = {pkt, ip[31 - 8 * k -: 8]};
        pkt = {pkt, 8'($urandom_range(0, 255))};
        pkt = {pkt, 8'($urandom_range(0, 255))};
      end
      repeat (tail) pkt = {pkt, 8'($urandom_range(0, 255))};
    end
    foreach (pkt[i]) feed_byte(pkt[i], i == pkt.size() - 1, 1'b0, slrp_pkg::ST_COMPLETE);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  task automatic check_result();
    slrp_pkg::result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing expected: kind %b ip %h port %h status %0d",
             out_result_kind, out_server_ip, out_server_port, out_packet_status);
      err_count++;
    end else begin
      exp_r = pending_results.pop_front();
      cmp_field("result_kind", 32'(exp_r.result_kind), 32'(out_result_kind));
      cmp_field("server_ip", exp_r.server_ip, out_server_ip);
      cmp_field("server_port", 32'(exp_r.server_port), 32'(out_server_port));
      cmp_field("packet_status", 32'(exp_r.packet_status), 32'(out_packet_status));
      cmp_field("last_of_run", 32'(exp_r.last_of_run), 32'(out_last_of_run));
    end
  endtask

  // Receiver: stall pattern switches between modes; one long hold-off fills the queue.
  initial begin : receiver
    int rx_cycles;
    int mode;
    int mode_left;
    int hold;
    rx_cycles = 0;
    mode = 0;
    mode_left = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rst_n && out_valid && out_ready) check_result();
      if (rx_cycles == HoldStart) hold = HoldLen;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 200);
      end else begin
        mode_left--;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NumDir; i++) begin
      feed_byte(DirRows[i].data, DirRows[i].pend, DirRows[i].typed, DirRows[i].stat);
    end
    while (bytes_sent < NumBytes) send_packet();
    in_valid <= 1'b0;
    in_packet_end <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
